/* rtl/lzss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared widths, constants, register codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lzss_pkg;

   localparam int CODE_W         = 8;
   localparam int COUNT_W        = 24;
   localparam int MATCH_BITS_W   = 3;
   localparam int DIST_W         = 16;
   localparam int LEN_W          = 7;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam int HISTORY_DEPTH_DEFAULT = 32768;

   localparam logic [CODE_W-1:0]       FLAG_TOP        = 8'h80;
   localparam logic [MATCH_BITS_W-1:0] MATCH_BITS_MIN  = 3'd1;
   localparam logic [MATCH_BITS_W-1:0] MATCH_BITS_MAX  = 3'd6;
   localparam logic [MATCH_BITS_W-1:0] MATCH_BITS_RST  = 3'd4;

   // register index, taken from paddr[2]
   localparam logic REG_MATCH_BITS = 1'b0;
   localparam logic REG_OUTPUT_LEN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } lzss_state_type;

endpackage : lzss_pkg
`default_nettype wire

/* rtl/lzss_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS request channel
// Valid/ready channel carrying one compressed code byte per transaction.
// ----------------------------------------------------------------------------
interface lzss_req_if
   import lzss_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink   (input valid, input code_byte, output ready);
endinterface : lzss_req_if
`default_nettype wire

/* rtl/lzss_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS response channel
// Valid/ready channel carrying one decompressed byte and its status flags.
// ----------------------------------------------------------------------------
interface lzss_rsp_if
   import lzss_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] data_byte;
   logic              end_of_run;
   logic              last_byte;
   logic              bad_distance;

   modport source (output valid, output data_byte, output end_of_run,
                   output last_byte, output bad_distance, input ready);
   modport sink   (input valid, input data_byte, input end_of_run,
                   input last_byte, input bad_distance, output ready);
endinterface : lzss_rsp_if
`default_nettype wire

/* rtl/lzss_byte_decompressor_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS byte decompressor core
// Decodes an LZSS byte stream (flag bytes, literals, 16-bit copy tokens)
// against a history RAM and emits one decompressed byte per transaction.
// ----------------------------------------------------------------------------
// Usage: program match_length_bits and output_length over the APB port, then
// stream code bytes. Flag bytes, token bytes and literals are taken in IDLE;
// a literal needs the output register free (or being drained). A copy token
// produces its bytes through the single history RAM: the READ state reads the
// source entry, the EMIT state emits the byte and writes it back, so that
// overlapping copies (distance 1) see fresh data. EMIT stalls while the output
// register is full; requests wait until the copy ends. Once output_length
// bytes are produced, further code bytes are accepted and dropped.
// ----------------------------------------------------------------------------
module lzss_byte_decompressor_core
   import lzss_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lzss_req_if.sink                   req_if,
   lzss_rsp_if.source                 rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int XW = DIST_W + 1;
   localparam logic [XW-1:0] DEPTH_X = XW'(HISTORY_DEPTH);
   localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

   logic [CODE_W-1:0] hist_mem [HISTORY_DEPTH];

   lzss_state_type state_ff, state_in;

   logic [MATCH_BITS_W-1:0] match_bits_ff;
   logic [COUNT_W-1:0]      output_length_ff;
   logic [COUNT_W-1:0]      bytes_written_ff;
   logic [AW-1:0]           wp_ff;
   logic [CODE_W-1:0]       flag_byte_ff;
   logic [CODE_W-1:0]       flag_mask_ff;
   logic                    phase_ff;
   logic [CODE_W-1:0]       token_high_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic                    dist_far_ff;
   logic [LEN_W-1:0]        count_ff;
   logic                    bad_ff;
   logic [CODE_W-1:0]       rd_data_ff;

   logic                    rsp_valid_ff;
   logic [CODE_W-1:0]       rsp_data_ff;
   logic                    rsp_eor_ff;
   logic                    rsp_last_ff;
   logic                    rsp_bad_ff;

   logic                    csr_wr;
   logic                    out_free;
   logic                    active;
   logic                    lit_expect;
   logic                    req_fire;
   logic                    lit_emit;
   logic                    copy_emit;
   logic [MATCH_BITS_W-1:0] bits;
   logic [DIST_W-1:0]       tok;
   logic [DIST_W-1:0]       tok_dist;
   logic [LEN_W-1:0]        tok_len;
   logic [COUNT_W-1:0]      remain;
   logic [LEN_W-1:0]        len_eff;
   logic [XW-1:0]           wp_x;
   logic [XW-1:0]           dist_x;
   logic [XW-1:0]           src_x;
   logic                    bad_now;
   logic                    emit_en;
   logic [CODE_W-1:0]       emit_byte;
   logic                    emit_eor;
   logic [AW-1:0]           wp_next;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         REG_MATCH_BITS: prdata = CSR_DATA_W'(match_bits_ff);
         REG_OUTPUT_LEN: prdata = CSR_DATA_W'(output_length_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_bits_ff    <= MATCH_BITS_RST;
         output_length_ff <= '0;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_MATCH_BITS: match_bits_ff    <= pwdata[MATCH_BITS_W-1:0];
            REG_OUTPUT_LEN: output_length_ff <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- decode ----------------
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign active     = bytes_written_ff < output_length_ff;
   assign lit_expect = active && !phase_ff && (flag_mask_ff != '0)
                       && ((flag_byte_ff & flag_mask_ff) == '0);
   assign req_if.ready = (state_ff == ST_IDLE) && (out_free || !lit_expect);
   assign req_fire   = req_if.valid && req_if.ready;
   assign lit_emit   = req_fire && lit_expect;
   assign copy_emit  = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      if (match_bits_ff < MATCH_BITS_MIN) begin
         bits = MATCH_BITS_MIN;
      end else if (match_bits_ff > MATCH_BITS_MAX) begin
         bits = MATCH_BITS_MAX;
      end else begin
         bits = match_bits_ff;
      end
   end

   assign tok      = {token_high_ff, req_if.code_byte};
   assign tok_dist = (tok >> bits) + DIST_W'(1);
   assign tok_len  = LEN_W'(tok & ((DIST_W'(1) << bits) - DIST_W'(1))) + LEN_W'(1);
   assign remain   = output_length_ff - bytes_written_ff;
   assign len_eff  = (COUNT_W'(tok_len) > remain) ? LEN_W'(remain) : tok_len;

   // source = (bytes_written - dist) mod depth, from the wrapped write pointer
   assign wp_x   = XW'(wp_ff);
   assign dist_x = XW'(dist_ff);
   assign src_x  = (wp_x >= dist_x) ? (wp_x - dist_x) : (wp_x + DEPTH_X - dist_x);
   assign bad_now = dist_far_ff || (COUNT_W'(dist_ff) > bytes_written_ff);

   assign emit_en   = lit_emit || copy_emit;
   assign emit_byte = lit_emit ? req_if.code_byte : (bad_ff ? '0 : rd_data_ff);
   assign emit_eor  = lit_emit || (count_ff == LEN_W'(1));
   assign wp_next   = (wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && active && phase_ff) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = (count_ff == LEN_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_written_ff <= '0;
         wp_ff            <= '0;
         flag_byte_ff     <= '0;
         flag_mask_ff     <= '0;
         phase_ff         <= 1'b0;
         token_high_ff    <= '0;
         count_ff         <= '0;
      end else begin
         if (req_fire && active) begin
            if (phase_ff) begin
               count_ff <= len_eff;
               phase_ff <= 1'b0;
            end else if (flag_mask_ff == '0) begin
               flag_byte_ff <= req_if.code_byte;
               flag_mask_ff <= FLAG_TOP;
            end else if (!lit_expect) begin
               token_high_ff <= req_if.code_byte;
               phase_ff      <= 1'b1;
            end else begin
               flag_mask_ff <= flag_mask_ff >> 1;
            end
         end
         if (copy_emit) begin
            count_ff <= count_ff - LEN_W'(1);
            if (count_ff == LEN_W'(1)) begin
               flag_mask_ff <= flag_mask_ff >> 1;
            end
         end
         if (emit_en) begin
            bytes_written_ff <= bytes_written_ff + COUNT_W'(1);
            wp_ff            <= wp_next;
         end
      end
   end

   // copy parameters, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire && active && phase_ff) begin
         dist_ff     <= tok_dist;
         dist_far_ff <= XW'(tok_dist) > DEPTH_X;
      end
      if (state_ff == ST_READ) begin
         bad_ff <= bad_now;
      end
   end

   // history RAM
   always_ff @(posedge clock) begin
      if (emit_en) begin
         hist_mem[wp_ff] <= emit_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= hist_mem[src_x[AW-1:0]];
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         rsp_data_ff <= emit_byte;
         rsp_eor_ff  <= emit_eor;
         rsp_last_ff <= (bytes_written_ff + COUNT_W'(1)) == output_length_ff;
         rsp_bad_ff  <= copy_emit && bad_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.data_byte    = rsp_data_ff;
   assign rsp_if.end_of_run   = rsp_eor_ff;
   assign rsp_if.last_byte    = rsp_last_ff;
   assign rsp_if.bad_distance = rsp_bad_ff;

   // ---------------- assertions ----------------
   a_busy_no_req : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_if.ready)
      else $error("request taken during copy");

   a_emit_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (count_ff != '0))
      else $error("copy emit with zero count");

   a_bad_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_data_ff == '0))
      else $error("bad distance byte not zero");

   a_last_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (bytes_written_ff == output_length_ff))
      else $error("last byte flag with bytes still owed");

   a_copy_end : assert property (@(posedge clock) disable iff (reset)
      (copy_emit && (count_ff == LEN_W'(1))) |=> (rsp_valid_ff && rsp_eor_ff
                                                   && state_ff == ST_IDLE))
      else $error("copy end not flagged");

endmodule : lzss_byte_decompressor_core
`default_nettype wire
